>>> hdl/sph_pair_force_accumulator_core_assert.svh
// Assertion macros for the SPH pair force accumulator.
// Included by the top-level core, the RTL file that carries concurrent assertions; needs clk and rst in scope.
`ifndef SPH_PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH
`define SPH_PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define SPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SPH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPH_ASSERT(lbl, prop, msg)
`define SPH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/sph_pkg.sv
// Shared constants, types and helper functions of the SPH pair force accumulator.
// Used by the multiplier, divider, root units and the top-level sequencer.
package sph_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PRES_FRAC = 8;
  localparam int WORD_W    = 64;
  localparam int MAG_W     = 62;
  localparam int REG_W     = 31;
  localparam int SUM_W     = 48;
  localparam int DEN_W     = 34;
  localparam int DIV_DW    = MAG_W + 2 * FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_DW);
  localparam int ROOT_W    = 32;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int PROD_W    = 2 * WORD_W;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic signed [WORD_W-1:0] sword_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam mag_t MAG_LIMIT = '1;
  localparam sword_t MAG_S = sword_t'({{(WORD_W-MAG_W){1'b0}}, MAG_LIMIT});
  localparam sword_t SUM_MAX = (sword_t'(1) <<< (SUM_W-1)) - sword_t'(1);
  localparam sword_t SUM_MIN = -(sword_t'(1) <<< (SUM_W-1));

  localparam logic [REG_W-1:0] ISH_RESET   = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] KNORM_RESET = REG_W'(29802);
  localparam logic [REG_W-1:0] MASS_RESET  = REG_W'(1000) << FRAC_BITS;
  localparam logic [REG_W-1:0] VISC_RESET  = REG_W'(66);
  localparam logic [REG_W-1:0] GRAV_RESET  = REG_W'(642908);
  localparam logic [REG_W-1:0] DENS_RESET  = REG_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    CFG_ISH   = 3'd0,
    CFG_KNORM = 3'd1,
    CFG_MASS  = 3'd2,
    CFG_VISC  = 3'd3,
    CFG_GRAV  = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    SH_F      = 2'd0,
    SH_2F     = 2'd1,
    SH_2F_PRS = 2'd2
  } div_shift_t;

  typedef enum logic [4:0] {
    ST_SQX, ST_SQY, ST_ROOT, ST_Q, ST_UU, ST_G,
    ST_PT1, ST_PT2, ST_PN1, ST_PN2, ST_VT1, ST_VT2, ST_VN1, ST_VN2,
    ST_EX, ST_EY, ST_EVX, ST_EVY,
    ST_C, ST_CP, ST_AXP, ST_AYP, ST_MM, ST_MV, ST_CV, ST_AXV, ST_AYV,
    ST_DX, ST_DY, ST_DR
  } step_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    mag_t              mag;
    logic [WORD_W-1:0] low;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    mag_t             num;
    div_shift_t       sh;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quo;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic sword_t with_sign(input logic neg, input mag_t m);
    sword_t v;
    v = sword_t'({{(WORD_W-MAG_W){1'b0}}, m});
    return neg ? -v : v;
  endfunction

  function automatic sword_t clamp_mag(input sword_t v);
    if (v > MAG_S) return MAG_S;
    if (v < -MAG_S) return -MAG_S;
    return v;
  endfunction

  function automatic sum_t acc_sum(input sum_t s, input sword_t t);
    sword_t r;
    r = sword_t'(s) + t;
    if (r > SUM_MAX) return sum_t'(SUM_MAX);
    if (r < SUM_MIN) return sum_t'(SUM_MIN);
    return sum_t'(r);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SUM_W+1:0] v);
    logic signed [SUM_W+1:0] hi;
    logic signed [SUM_W+1:0] lo;
    hi = (SUM_W+2)'(32'sh7FFF_FFFF);
    lo = -(hi + (SUM_W+2)'(1));
    if (v > hi) return 32'h7FFF_FFFF;
    if (v < lo) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

>>> hdl/sph_pair_force_accumulator_core.sv
// SPH pair force accumulator, top level: stream ports, configuration, state and sequencer.
// Depends on sph_pkg, sph_mul, sph_div, sph_sqrt and the assertion macro header.
//
// One target particle is loaded by a beat with func clear, then each neighbor beat adds its
// cubic-spline pressure, viscous and continuity terms; a beat with tlast set produces one
// result beat. A load or skipped (self) beat goes straight to the finish state. A neighbor's
// work is dominated by twelve quotients on the bit-serial divider, plus seventeen products
// on the shared multiplier and the root; a neighbor beyond twice the smoothing length or at
// zero distance stops after the root or the scaled-distance product. The input is not ready
// while a neighbor is in work; a waiting result holds off the next input beat only when the
// current beat also carries tlast and so has a result of its own to load.
module sph_pair_force_accumulator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], density[158:128],
  // pressure[190:159], zero pad[191]
  input  logic [191:0] s_tdata,
  // func[0], is_self[1]
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accel_x[31:0], accel_y[63:32], density_rate[95:64]
  output logic [95:0]  m_tdata,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam int F = sph_pkg::FRAC_BITS;
  localparam int RW = sph_pkg::REG_W;
  localparam int WW = sph_pkg::WORD_W;

  state_t         state;
  sph_pkg::step_t step;

  logic [RW-1:0] ish, knorm, mass, visc, grav;
  logic signed [31:0] tpx, tpy, tvx, tvy, tpres;
  logic [RW-1:0]      tden;
  sph_pkg::sum_t      sax, say, sdr;
  logic               item_last;

  // Neighbor working registers.
  logic [32:0]        adx, ady, advx, advy;
  logic               sdx, sdy, sdvx, sdvy, pre;
  logic [31:0]        sx, sy;
  logic [RW-1:0]      nrho;
  logic signed [31:0] npres;
  logic [WW-1:0]      vsum;
  logic [32:0]        sep;
  sph_pkg::mag_t      q, w, g, tmp, vr, ex, ey, evx, evy, c, cp;
  sph_pkg::sword_t    pr, dot;
  logic [95:0]        out_data;

  sph_pkg::mul_req_t  mul_req;
  sph_pkg::mul_rsp_t  mul_rsp;
  sph_pkg::div_req_t  div_req;
  sph_pkg::div_rsp_t  div_rsp;
  sph_pkg::sqrt_req_t sqrt_req;
  sph_pkg::sqrt_rsp_t sqrt_rsp;

  logic               accept;
  logic               unit_done;
  logic [2:0]         unit_dones;
  logic [2:0]         unit_starts;
  logic               stop_early;
  logic               out_load;
  logic               is_div;
  logic               is_sqrt;
  logic               can_load;
  logic [RW-1:0]      rt;
  logic               q_le1;
  sph_pkg::mag_t      u;
  sph_pkg::mag_t      w_new;
  sph_pkg::mag_t      pr_abs;
  logic [WW-1:0]      dot_abs;
  logic [32:0]        sep_new;
  logic [31:0]        tpres_abs, npres_abs;
  logic [sph_pkg::MAG_W:0] vr_sum;

  // Input fields and the per-neighbor differences.
  logic signed [31:0] in_px, in_py, in_vx, in_vy, in_pres;
  logic [RW-1:0]      in_rho;
  logic signed [32:0] dx, dy, dvx, dvy;
  logic [32:0]        adx_in, ady_in;
  logic               pre_in;

  assign in_px   = s_tdata[31:0];
  assign in_py   = s_tdata[63:32];
  assign in_vx   = s_tdata[95:64];
  assign in_vy   = s_tdata[127:96];
  assign in_rho  = s_tdata[158:128];
  assign in_pres = s_tdata[190:159];

  assign dx  = {tpx[31], tpx} - {in_px[31], in_px};
  assign dy  = {tpy[31], tpy} - {in_py[31], in_py};
  assign dvx = {tvx[31], tvx} - {in_vx[31], in_vx};
  assign dvy = {tvy[31], tvy} - {in_vy[31], in_vy};
  assign adx_in = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady_in = dy[32] ? 33'(-dy) : 33'(dy);
  // Separations of 2^31 or more are halved before squaring and the root doubled.
  assign pre_in = (|adx_in[32:31]) || (|ady_in[32:31]);

  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign unit_dones  = {mul_rsp.done, div_rsp.done, sqrt_rsp.done};
  assign unit_starts = {mul_req.start, div_req.start, sqrt_req.start};
  assign unit_done   = |unit_dones;
  assign can_load    = !m_tvalid || m_tready;
  assign out_load    = (state == S_FIN) && item_last && can_load;

  assign rt        = (tden == '0) ? RW'(1) : tden;
  assign q_le1     = q <= (sph_pkg::mag_t'(1) << F);
  assign u         = q_le1 ? q : (sph_pkg::mag_t'(2) << F) - q;
  assign w_new     = q_le1 ? (q + (q << 1)) - (((mul_rsp.mag << 3) + mul_rsp.mag) >> 2)
                           : ((mul_rsp.mag << 1) + mul_rsp.mag) >> 2;
  assign pr_abs    = pr[WW-1] ? sph_pkg::mag_t'(-pr) : sph_pkg::mag_t'(pr);
  assign dot_abs   = dot[WW-1] ? WW'(-dot) : WW'(dot);
  assign sep_new   = {1'b0, sqrt_rsp.root} << pre;
  assign tpres_abs = tpres[31] ? 32'(-tpres) : 32'(tpres);
  assign npres_abs = npres[31] ? 32'(-npres) : 32'(npres);
  assign vr_sum    = {1'b0, vr} + {1'b0, div_rsp.quo};

  // Coincident neighbors and neighbors beyond reach end the pair early.
  assign stop_early = ((step == sph_pkg::ST_ROOT) && (sep_new == '0)) ||
                      ((step == sph_pkg::ST_Q) && (mul_rsp.mag > (sph_pkg::mag_t'(2) << F)));

  always_comb begin
    is_sqrt = (step == sph_pkg::ST_ROOT);
    is_div  = step inside {[sph_pkg::ST_PT1:sph_pkg::ST_EVY]};
    mul_req.start  = (state == S_RUN) && !is_sqrt && !is_div;
    div_req.start  = (state == S_RUN) && is_div;
    sqrt_req.start = (state == S_RUN) && is_sqrt;
    sqrt_req.value = vsum;
    mul_req.a   = '0;
    mul_req.b   = '0;
    div_req.num = '0;
    div_req.sh  = sph_pkg::SH_F;
    div_req.den = sph_pkg::DEN_W'(rt);
    case (step)
      sph_pkg::ST_SQX: begin mul_req.a = WW'(sx);    mul_req.b = WW'(sx); end
      sph_pkg::ST_SQY: begin mul_req.a = WW'(sy);    mul_req.b = WW'(sy); end
      sph_pkg::ST_Q:   begin mul_req.a = WW'(sep);   mul_req.b = WW'(ish); end
      sph_pkg::ST_UU:  begin mul_req.a = WW'(u);     mul_req.b = WW'(u); end
      sph_pkg::ST_G:   begin mul_req.a = WW'(knorm); mul_req.b = WW'(w); end
      sph_pkg::ST_PT1: begin div_req.num = sph_pkg::mag_t'(tpres_abs); end
      sph_pkg::ST_PT2: begin div_req.num = tmp; div_req.sh = sph_pkg::SH_2F_PRS; end
      sph_pkg::ST_PN1: begin
        div_req.num = sph_pkg::mag_t'(npres_abs);
        div_req.den = sph_pkg::DEN_W'(nrho);
      end
      sph_pkg::ST_PN2: begin
        div_req.num = tmp;
        div_req.sh  = sph_pkg::SH_2F_PRS;
        div_req.den = sph_pkg::DEN_W'(nrho);
      end
      sph_pkg::ST_VT1: begin div_req.num = sph_pkg::mag_t'(1); div_req.sh = sph_pkg::SH_2F; end
      sph_pkg::ST_VT2: begin div_req.num = tmp; end
      sph_pkg::ST_VN1: begin
        div_req.num = sph_pkg::mag_t'(1);
        div_req.sh  = sph_pkg::SH_2F;
        div_req.den = sph_pkg::DEN_W'(nrho);
      end
      sph_pkg::ST_VN2: begin div_req.num = tmp; div_req.den = sph_pkg::DEN_W'(nrho); end
      sph_pkg::ST_EX:  begin
        div_req.num = sph_pkg::mag_t'(adx);  div_req.den = sph_pkg::DEN_W'(sep);
      end
      sph_pkg::ST_EY:  begin
        div_req.num = sph_pkg::mag_t'(ady);  div_req.den = sph_pkg::DEN_W'(sep);
      end
      sph_pkg::ST_EVX: begin
        div_req.num = sph_pkg::mag_t'(advx); div_req.den = sph_pkg::DEN_W'(sep);
      end
      sph_pkg::ST_EVY: begin
        div_req.num = sph_pkg::mag_t'(advy); div_req.den = sph_pkg::DEN_W'(sep);
      end
      sph_pkg::ST_C:   begin mul_req.a = WW'(mass); mul_req.b = WW'(g); end
      sph_pkg::ST_CP:  begin mul_req.a = WW'(c);    mul_req.b = WW'(pr_abs); end
      sph_pkg::ST_AXP: begin mul_req.a = WW'(cp);   mul_req.b = WW'(ex); end
      sph_pkg::ST_AYP: begin mul_req.a = WW'(cp);   mul_req.b = WW'(ey); end
      sph_pkg::ST_MM:  begin mul_req.a = WW'(visc); mul_req.b = WW'(mass); end
      sph_pkg::ST_MV:  begin mul_req.a = WW'(tmp);  mul_req.b = WW'(vr); end
      sph_pkg::ST_CV:  begin mul_req.a = WW'(tmp);  mul_req.b = WW'(g); end
      sph_pkg::ST_AXV: begin mul_req.a = WW'(cp);   mul_req.b = WW'(evx); end
      sph_pkg::ST_AYV: begin mul_req.a = WW'(cp);   mul_req.b = WW'(evy); end
      sph_pkg::ST_DX:  begin mul_req.a = WW'(advx); mul_req.b = WW'(ex); end
      sph_pkg::ST_DY:  begin mul_req.a = WW'(advy); mul_req.b = WW'(ey); end
      sph_pkg::ST_DR:  begin mul_req.a = WW'(c);    mul_req.b = dot_abs; end
      default: ;
    endcase
  end

  sph_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  sph_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sph_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // Control, configuration, target and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= sph_pkg::ST_SQX;
      m_tvalid  <= 1'b0;
      item_last <= 1'b0;
      ish       <= sph_pkg::ISH_RESET;
      knorm     <= sph_pkg::KNORM_RESET;
      mass      <= sph_pkg::MASS_RESET;
      visc      <= sph_pkg::VISC_RESET;
      grav      <= sph_pkg::GRAV_RESET;
      tpx       <= '0;
      tpy       <= '0;
      tvx       <= '0;
      tvy       <= '0;
      tpres     <= '0;
      tden      <= sph_pkg::DENS_RESET;
      sax       <= '0;
      say       <= '0;
      sdr       <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wen) begin
        case (cfg_index)
          sph_pkg::CFG_ISH:   ish   <= cfg_wdata;
          sph_pkg::CFG_KNORM: knorm <= cfg_wdata;
          sph_pkg::CFG_MASS:  mass  <= cfg_wdata;
          sph_pkg::CFG_VISC:  visc  <= cfg_wdata;
          sph_pkg::CFG_GRAV:  grav  <= cfg_wdata;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_last <= s_tlast;
            step      <= sph_pkg::ST_SQX;
            if (!s_tuser[0]) begin
              tpx   <= in_px;
              tpy   <= in_py;
              tvx   <= in_vx;
              tvy   <= in_vy;
              tden  <= in_rho;
              tpres <= in_pres;
              sax   <= '0;
              say   <= '0;
              sdr   <= '0;
              state <= S_FIN;
            end else if (s_tuser[1]) begin
              state <= S_FIN;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: state <= S_WAIT;
        S_WAIT: begin
          if (unit_done) begin
            if (stop_early || (step == sph_pkg::ST_DR)) begin
              state <= S_FIN;
            end else begin
              state <= S_RUN;
              step  <= sph_pkg::step_t'(step + 5'd1);
            end
            case (step)
              sph_pkg::ST_AXP:
                sax <= sph_pkg::acc_sum(sax, sph_pkg::with_sign(pr[WW-1] ^ sdx, mul_rsp.mag));
              sph_pkg::ST_AYP:
                say <= sph_pkg::acc_sum(say, sph_pkg::with_sign(pr[WW-1] ^ sdy, mul_rsp.mag));
              sph_pkg::ST_AXV:
                sax <= sph_pkg::acc_sum(sax, sph_pkg::with_sign(!sdvx, mul_rsp.mag));
              sph_pkg::ST_AYV:
                say <= sph_pkg::acc_sum(say, sph_pkg::with_sign(!sdvy, mul_rsp.mag));
              sph_pkg::ST_DR:
                sdr <= sph_pkg::acc_sum(sdr, sph_pkg::with_sign(!dot[WW-1], mul_rsp.mag));
              default: ;
            endcase
          end
        end
        S_FIN: begin
          if (!item_last || can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the current neighbor and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      adx   <= adx_in;
      ady   <= ady_in;
      advx  <= dvx[32] ? 33'(-dvx) : 33'(dvx);
      advy  <= dvy[32] ? 33'(-dvy) : 33'(dvy);
      sdx   <= dx[32];
      sdy   <= dy[32];
      sdvx  <= dvx[32];
      sdvy  <= dvy[32];
      pre   <= pre_in;
      sx    <= pre_in ? adx_in[32:1] : adx_in[31:0];
      sy    <= pre_in ? ady_in[32:1] : ady_in[31:0];
      nrho  <= (in_rho == '0) ? RW'(1) : in_rho;
      npres <= in_pres;
    end
    if (state == S_WAIT && unit_done) begin
      case (step)
        sph_pkg::ST_SQX:  vsum <= mul_rsp.low;
        sph_pkg::ST_SQY:  vsum <= vsum + mul_rsp.low;
        sph_pkg::ST_ROOT: sep  <= sep_new;
        sph_pkg::ST_Q:    q    <= mul_rsp.mag;
        sph_pkg::ST_UU:   w    <= w_new;
        sph_pkg::ST_G:    g    <= mul_rsp.mag;
        sph_pkg::ST_PT1, sph_pkg::ST_PN1, sph_pkg::ST_VT1, sph_pkg::ST_VN1:
          tmp <= div_rsp.quo;
        sph_pkg::ST_PT2:  pr <= sph_pkg::with_sign(tpres[31], div_rsp.quo);
        sph_pkg::ST_PN2:
          pr <= sph_pkg::clamp_mag(pr + sph_pkg::with_sign(npres[31], div_rsp.quo));
        sph_pkg::ST_VT2:  vr <= div_rsp.quo;
        sph_pkg::ST_VN2:
          vr <= vr_sum[sph_pkg::MAG_W] ? sph_pkg::MAG_LIMIT : vr_sum[sph_pkg::MAG_W-1:0];
        sph_pkg::ST_EX:   ex  <= div_rsp.quo;
        sph_pkg::ST_EY:   ey  <= div_rsp.quo;
        sph_pkg::ST_EVX:  evx <= div_rsp.quo;
        sph_pkg::ST_EVY:  evy <= div_rsp.quo;
        sph_pkg::ST_C:    c   <= mul_rsp.mag;
        sph_pkg::ST_CP, sph_pkg::ST_CV: cp <= mul_rsp.mag;
        sph_pkg::ST_MM, sph_pkg::ST_MV: tmp <= mul_rsp.mag;
        sph_pkg::ST_DX:   dot <= sph_pkg::with_sign(sdvx ^ sdx, mul_rsp.mag);
        sph_pkg::ST_DY:   dot <= dot + sph_pkg::with_sign(sdvy ^ sdy, mul_rsp.mag);
        default: ;
      endcase
    end
    if (out_load) begin
      out_data[31:0]  <= sph_pkg::sat32((sph_pkg::SUM_W+2)'(sax));
      out_data[63:32] <= sph_pkg::sat32((sph_pkg::SUM_W+2)'(say) -
                                        (sph_pkg::SUM_W+2)'({1'b0, grav}));
      out_data[95:64] <= sph_pkg::sat32((sph_pkg::SUM_W+2)'(sdr));
    end
  end

  assign m_tdata = out_data;

`include "sph_pair_force_accumulator_core_assert.svh"

  `SPH_ASSERT(a_one_unit_done, $onehot0(unit_dones), "two arithmetic units finished together")
  `SPH_ASSERT(a_done_in_wait, unit_done |-> (state == S_WAIT), "unit finished outside wait")
  `SPH_ASSERT(a_one_start, (state == S_RUN) |-> $onehot(unit_starts), "issue did not start one unit")
  `SPH_ASSERT(a_result_after_fin, $rose(m_tvalid) |-> $past(state == S_FIN), "result outside finish")

endmodule

>>> hdl/sph_mul.sv
// Shared 64 x 64 multiplier built from four 32 x 32 partial products, accumulated in turn.
// Gives the raw low word and the product shifted by FRAC_BITS, saturated. Uses sph_pkg.
module sph_mul (
  input  logic             clk,
  input  logic             rst,
  input  sph_pkg::mul_req_t req,
  output sph_pkg::mul_rsp_t rsp
);

  logic [sph_pkg::WORD_W-1:0] a_r;
  logic [sph_pkg::WORD_W-1:0] b_r;
  logic [sph_pkg::PROD_W-1:0] acc;
  logic [sph_pkg::PROD_W-1:0] pp_sh;
  logic [sph_pkg::WORD_W-1:0] pp;
  logic [31:0]                a_sel;
  logic [31:0]                b_sel;
  logic [1:0]                 k;
  logic                       busy;
  logic                       done;

  // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1.
  assign a_sel = k[1] ? a_r[63:32] : a_r[31:0];
  assign b_sel = k[0] ? b_r[63:32] : b_r[31:0];
  assign pp    = a_sel * b_sel;

  always_comb begin
    case (k)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        k    <= 2'd0;
      end else if (busy) begin
        k <= k + 2'd1;
        if (k == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

  assign rsp.done = done;
  assign rsp.low  = acc[sph_pkg::WORD_W-1:0];
  assign rsp.mag  = (|acc[sph_pkg::PROD_W-1:sph_pkg::FRAC_BITS+sph_pkg::MAG_W]) ?
                    sph_pkg::MAG_LIMIT :
                    acc[sph_pkg::FRAC_BITS+sph_pkg::MAG_W-1:sph_pkg::FRAC_BITS];

endmodule

>>> hdl/sph_div.sv
// Bit-serial restoring divider: (num << sh) / den, one quotient bit per cycle.
// Quotients of 2^62 or more, and a zero divisor, saturate. Uses sph_pkg.
module sph_div (
  input  logic             clk,
  input  logic             rst,
  input  sph_pkg::div_req_t req,
  output sph_pkg::div_rsp_t rsp
);

  logic [sph_pkg::DIV_DW-1:0]    dvd;
  logic [sph_pkg::DIV_DW-1:0]    quo;
  logic [sph_pkg::DEN_W-1:0]     rem;
  logic [sph_pkg::DEN_W-1:0]     den_r;
  logic [sph_pkg::DIV_CNT_W-1:0] cnt;
  logic                          zero_den;
  logic                          busy;
  logic                          done;
  logic [sph_pkg::DEN_W:0]       rsh;
  logic [sph_pkg::DEN_W:0]       diff;
  logic                          ge;

  assign rsh  = {rem, dvd[sph_pkg::DIV_DW-1]};
  assign diff = rsh - {1'b0, den_r};
  assign ge   = rsh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sph_pkg::DIV_CNT_W'(sph_pkg::DIV_DW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.sh)
        sph_pkg::SH_F:      dvd <= sph_pkg::DIV_DW'(req.num) << sph_pkg::FRAC_BITS;
        sph_pkg::SH_2F:     dvd <= sph_pkg::DIV_DW'(req.num) << (2 * sph_pkg::FRAC_BITS);
        sph_pkg::SH_2F_PRS: dvd <= sph_pkg::DIV_DW'(req.num) <<
                                   (2 * sph_pkg::FRAC_BITS - sph_pkg::PRES_FRAC);
        default:            dvd <= sph_pkg::DIV_DW'(req.num);
      endcase
      rem      <= '0;
      quo      <= '0;
      den_r    <= req.den;
      zero_den <= (req.den == '0);
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= ge ? diff[sph_pkg::DEN_W-1:0] : rsh[sph_pkg::DEN_W-1:0];
      quo <= {quo[sph_pkg::DIV_DW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = (zero_den || (|quo[sph_pkg::DIV_DW-1:sph_pkg::MAG_W])) ?
                    sph_pkg::MAG_LIMIT : quo[sph_pkg::MAG_W-1:0];

endmodule

>>> hdl/sph_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
// Uses sph_pkg for widths and the request and response types.
module sph_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  sph_pkg::sqrt_req_t req,
  output sph_pkg::sqrt_rsp_t rsp
);

  logic [sph_pkg::WORD_W-1:0]     v;
  logic [sph_pkg::WORD_W-1:0]     r;
  logic [sph_pkg::WORD_W-1:0]     b;
  logic [sph_pkg::WORD_W-1:0]     t;
  logic [sph_pkg::ROOT_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;

  assign t = r + b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sph_pkg::ROOT_CNT_W'(sph_pkg::ROOT_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      v <= req.value;
      r <= '0;
      b <= sph_pkg::WORD_W'(1) << (sph_pkg::WORD_W - 2);
    end else if (busy) begin
      if (v >= t) begin
        v <= v - t;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

  assign rsp.done = done;
  assign rsp.root = r[sph_pkg::ROOT_W-1:0];

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of sph_pair_force_accumulator_core: targets, neighbor beats and
// configuration phases, with a bit-exact predictor of the fixed-point sums. Needs sph_pkg.
module tb;

  typedef logic [63:0] u64_t;
  localparam u64_t MAG = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint LIMIT_CYCLES = 15000000;
  localparam int NEIGHBOR_LAT = 1500;

  typedef struct {
    logic        func;
    logic [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [30:0] density;
    logic [31:0] pressure;
    logic        is_self, last;
  } particle_beat_t;

  typedef struct {
    logic [31:0] accel_x, accel_y, density_rate;
  } force_result_t;

  logic clk = 0, rst = 1;
  logic s_tvalid, s_tready, s_tlast, m_tvalid, m_tready, cfg_wen;
  logic [191:0] s_tdata;
  logic [1:0] s_tuser;
  logic [95:0] m_tdata;
  sph_pkg::cfg_index_t cfg_index;
  logic [30:0] cfg_wdata;

  sph_pair_force_accumulator_core u_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  force_result_t pending_forces[$];
  int errors = 0, hold_cnt = 0;
  bit no_idle = 0;
  longint cycles = 0;

  // Predictor state and configuration copies.
  u64_t inv_h, knorm, mass, visc, grav;
  longint tgt_px, tgt_py, tgt_vx, tgt_vy, tgt_pres;
  u64_t tgt_rho;
  longint acc_ax, acc_ay, acc_dr;

  function automatic u64_t fx_mul(u64_t a, u64_t b, int sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (p > MAG) ? MAG : p[63:0];
  endfunction

  function automatic u64_t fx_div(u64_t num, int sh, u64_t den);
    logic [127:0] q;
    if (den == 0) return MAG;
    q = ({64'b0, num} << sh) / {64'b0, den};
    return (q > MAG) ? MAG : q[63:0];
  endfunction

  function automatic u64_t int_root(u64_t v);
    u64_t r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic u64_t magn(longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic longint signed_mag(bit neg, u64_t m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint add_sat48(longint s, longint t);
    longint r;
    r = s + t;
    if (r > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (r < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return r;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint pres_over_rho2(longint p, u64_t rho);
    u64_t d;
    d = fx_div(magn(p), sph_pkg::FRAC_BITS, rho);
    d = fx_div(d, 2 * sph_pkg::FRAC_BITS - sph_pkg::PRES_FRAC, rho);
    return signed_mag(p < 0, d);
  endfunction

  function automatic u64_t recip_rho2(u64_t rho);
    return fx_div(fx_div(1, 2 * sph_pkg::FRAC_BITS, rho), sph_pkg::FRAC_BITS, rho);
  endfunction

  task automatic add_neighbor(longint px, longint py, longint vx, longint vy, u64_t rho,
                              longint pn);
    longint dx, dy, dvx, dvy, pr, dot;
    u64_t adx, ady, advx, advy, sx, sy, sep, q, w, g, rt, c, cp, cv, ex, ey, m, vr, q2, t;
    int pre;
    dx = tgt_px - px; dy = tgt_py - py;
    dvx = tgt_vx - vx; dvy = tgt_vy - vy;
    adx = magn(dx); ady = magn(dy); advx = magn(dvx); advy = magn(dvy);
    // Separations of 2^31 or more are halved before squaring to keep the sum in range.
    pre = (adx >= (64'd1 << 31) || ady >= (64'd1 << 31)) ? 1 : 0;
    sx = adx >> pre; sy = ady >> pre;
    sep = int_root(sx * sx + sy * sy) << pre;
    if (sep == 0) return;
    q = fx_mul(sep, inv_h, sph_pkg::FRAC_BITS);
    if (q > (64'd2 << sph_pkg::FRAC_BITS)) return;
    if (q <= (64'd1 << sph_pkg::FRAC_BITS)) begin
      q2 = (q * q) >> sph_pkg::FRAC_BITS;
      w = 3 * q - ((9 * q2) >> 2);
    end else begin
      t = (64'd2 << sph_pkg::FRAC_BITS) - q;
      w = (3 * ((t * t) >> sph_pkg::FRAC_BITS)) >> 2;
    end
    g = fx_mul(knorm, w, sph_pkg::FRAC_BITS);
    rt = tgt_rho == 0 ? 1 : tgt_rho;
    if (rho == 0) rho = 1;
    pr = pres_over_rho2(tgt_pres, rt) + pres_over_rho2(pn, rho);
    if (pr > longint'(MAG)) pr = longint'(MAG);
    if (pr < -longint'(MAG)) pr = -longint'(MAG);
    vr = recip_rho2(rt) + recip_rho2(rho);
    if (vr > MAG) vr = MAG;
    ex = fx_div(adx, sph_pkg::FRAC_BITS, sep);
    ey = fx_div(ady, sph_pkg::FRAC_BITS, sep);
    c = fx_mul(mass, g, sph_pkg::FRAC_BITS);
    cp = fx_mul(c, magn(pr), sph_pkg::FRAC_BITS);
    acc_ax = add_sat48(acc_ax, signed_mag((pr < 0) != (dx < 0),
                       fx_mul(cp, ex, sph_pkg::FRAC_BITS)));
    acc_ay = add_sat48(acc_ay, signed_mag((pr < 0) != (dy < 0),
                       fx_mul(cp, ey, sph_pkg::FRAC_BITS)));
    m = fx_mul(visc, mass, sph_pkg::FRAC_BITS);
    cv = fx_mul(fx_mul(m, vr, sph_pkg::FRAC_BITS), g, sph_pkg::FRAC_BITS);
    acc_ax = add_sat48(acc_ax, signed_mag(dvx >= 0,
                       fx_mul(cv, fx_div(advx, sph_pkg::FRAC_BITS, sep), sph_pkg::FRAC_BITS)));
    acc_ay = add_sat48(acc_ay, signed_mag(dvy >= 0,
                       fx_mul(cv, fx_div(advy, sph_pkg::FRAC_BITS, sep), sph_pkg::FRAC_BITS)));
    dot = signed_mag((dvx < 0) != (dx < 0), fx_mul(advx, ex, sph_pkg::FRAC_BITS))
        + signed_mag((dvy < 0) != (dy < 0), fx_mul(advy, ey, sph_pkg::FRAC_BITS));
    acc_dr = add_sat48(acc_dr, signed_mag(dot >= 0, fx_mul(c, magn(dot), sph_pkg::FRAC_BITS)));
  endtask

  task automatic predict_beat(particle_beat_t b);
    force_result_t r;
    if (b.func == 0) begin
      tgt_px = longint'($signed(b.pos_x)); tgt_py = longint'($signed(b.pos_y));
      tgt_vx = longint'($signed(b.vel_x)); tgt_vy = longint'($signed(b.vel_y));
      tgt_rho = u64_t'(b.density);
      tgt_pres = longint'($signed(b.pressure));
      acc_ax = 0; acc_ay = 0; acc_dr = 0;
    end else if (!b.is_self) begin
      add_neighbor($signed(b.pos_x), $signed(b.pos_y), $signed(b.vel_x), $signed(b.vel_y),
                   u64_t'(b.density), $signed(b.pressure));
    end
    if (b.last) begin
      r.accel_x = clip32(acc_ax);
      r.accel_y = clip32(acc_ay - longint'(grav));
      r.density_rate = clip32(acc_dr);
      pending_forces = {pending_forces, r};
    end
  endtask

  task automatic send_beat(particle_beat_t b);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, b.pressure, b.density, b.vel_y, b.vel_x, b.pos_y, b.pos_x};
    s_tuser <= {b.is_self, b.func};
    s_tlast <= b.last;
    do @(posedge clk); while (!s_tready);
    predict_beat(b);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** sph_pair_force_accumulator_core: FAILED **");
      $finish;
    end
  end

  // Result side: check accepted beats and drive ready, with a counted hold-off.
  always @(posedge clk) begin
    force_result_t e;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_forces.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
        end else begin
          e = pending_forces.pop_front();
          if (m_tdata[31:0] !== e.accel_x) report_mismatch("accel_x", m_tdata[31:0], e.accel_x);
          if (m_tdata[63:32] !== e.accel_y) report_mismatch("accel_y", m_tdata[63:32], e.accel_y);
          if (m_tdata[95:64] !== e.density_rate)
            report_mismatch("density_rate", m_tdata[95:64], e.density_rate);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic write_config(u64_t ih, u64_t kn, u64_t ms, u64_t vs, u64_t gr);
    sph_pkg::cfg_index_t idx[5];
    u64_t val[5];
    idx = '{sph_pkg::CFG_ISH, sph_pkg::CFG_KNORM, sph_pkg::CFG_MASS, sph_pkg::CFG_VISC,
            sph_pkg::CFG_GRAV};
    val = '{ih, kn, ms, vs, gr};
    for (int i = 0; i < 5; i++) begin
      cfg_wen <= 1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i][30:0];
      @(posedge clk);
    end
    cfg_wen <= 0;
    inv_h = ih; knorm = kn; mass = ms; visc = vs; grav = gr;
  endtask

  // Wait for every result, then let a neighbor still in work finish.
  task automatic drain;
    s_tvalid <= 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (NEIGHBOR_LAT) @(posedge clk);
  endtask

  function automatic particle_beat_t mk(logic func, longint px, longint py, longint vx,
                                        longint vy, longint rho, longint p, logic self_n,
                                        logic last_n);
    particle_beat_t b;
    b.func = func; b.pos_x = px[31:0]; b.pos_y = py[31:0];
    b.vel_x = vx[31:0]; b.vel_y = vy[31:0]; b.density = rho[30:0];
    b.pressure = p[31:0]; b.is_self = self_n; b.last = last_n;
    return b;
  endfunction

  function automatic longint srand(int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  task automatic test_directed;
    longint one;
    one = 65536;
    send_beat(mk(0, 0, 0, one, -one, one, 1000 * 256, 0, 0));
    send_beat(mk(1, one, 0, 0, 0, one, 500 * 256, 0, 0));
    send_beat(mk(1, one / 2, one / 2, one, one, 2 * one, -300 * 256, 0, 0));
    send_beat(mk(1, 2 * one, 0, 0, 0, one, 0, 0, 0));          // q exactly two
    send_beat(mk(1, 2 * one + 1, 0, 0, 0, one, 0, 0, 0));      // just beyond reach
    send_beat(mk(1, 0, 0, 5, 5, one, 0, 0, 0));                 // coincident
    send_beat(mk(1, 100, 200, 7, 7, one, 99, 1, 0));            // self
    send_beat(mk(1, 300, -400, 0, 0, 0, 1, 0, 1));              // zero density
    send_beat(mk(1, -one, one, 32'sh7FFF_FFFF, -32'sh8000_0000, 31'h7FFF_FFFF,
                 -32'sh8000_0000, 0, 1));                      // items after last
    send_beat(mk(0, -32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF,
                 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1));        // last on load
    send_beat(mk(1, 32'sh7FFF_FFFF, -32'sh8000_0000, 0, 0, 1, -32'sh8000_0000, 0, 1));
    send_beat(mk(0, 0, 0, 0, 0, 0, -32'sh8000_0000, 0, 0));    // zero target density
    send_beat(mk(1, 1, 0, 32'sh7FFF_FFFF, 0, 1, 32'sh7FFF_FFFF, 0, 0));
    send_beat(mk(1, 0, -3, 0, -32'sh8000_0000, 31'h7FFF_FFFF, 0, 0, 1));
    drain();
  endtask

  task automatic random_sequences(int n_items);
    int sent, n;
    longint tx, ty;
    particle_beat_t b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        b = mk(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        b.density = {1'($urandom_range(1)), b.density[29:0]};
        send_beat(b);
        sent++;
      end else begin
        tx = srand(1 << 22); ty = srand(1 << 22);
        send_beat(mk(0, tx, ty, srand(1 << 20), srand(1 << 20), $urandom_range(1 << 20, 1 << 14),
                     $urandom, 0, $urandom_range(15) == 0));
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(9))
            0: b = mk(1, tx, ty, 0, 0, 1 << 16, 0, 1, 0);
            1: b = mk(1, tx + srand(1 << 24), ty + srand(1 << 24), srand(1 << 20),
                      srand(1 << 20), $urandom_range(1 << 20, 1 << 14), $urandom, 0, 0);
            default: b = mk(1, tx + srand(1 << 17), ty + srand(1 << 17), srand(1 << 20),
                            srand(1 << 20), $urandom_range(1 << 20, 1 << 14), $urandom, 0, 0);
          endcase
          b.last = (i == n - 1);
          send_beat(b);
        end
        sent += n + 1;
      end
    end
    drain();
  endtask

  task automatic test_default_config;
    random_sequences(500);
  endtask

  task automatic test_config_extremes;
    write_config(1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_sequences(80);
    write_config(31'h7FFF_FFFF, 0, 0, 0, 0);
    random_sequences(80);
    write_config(65536 / 8, 31'h7FFF_FFFF, 65536, 31'h7FFF_FFFF, 0);
    random_sequences(100);
  endtask

  task automatic test_backpressure;
    write_config(65536, 29802, 65536000, 66, 642908);
    hold_cnt = 4000;
    no_idle = 1;
    for (int i = 0; i < 40; i++)
      send_beat(mk(0, $urandom, $urandom, $urandom, $urandom, $urandom_range(1 << 20, 1),
                   $urandom, 0, 1));
    random_sequences(200);
    no_idle = 0;
  endtask

  task automatic test_random_config;
    for (int k = 0; k < 4; k++) begin
      write_config($urandom_range(1 << 18, 1 << 14), $urandom_range(1 << 20),
                   $urandom_range(31'h7FFF_FFFF), $urandom_range(1 << 16), $urandom_range(1 << 24));
      random_sequences(200);
    end
  endtask

  initial begin
    s_tvalid <= 0; s_tdata <= '0; s_tuser <= '0; s_tlast <= 0;
    cfg_wen <= 0; cfg_index <= sph_pkg::CFG_ISH; cfg_wdata <= '0;
    inv_h = 65536; knorm = 29802; mass = 65536000; visc = 66; grav = 642908;
    tgt_px = 0; tgt_py = 0; tgt_vx = 0; tgt_vy = 0; tgt_pres = 0; tgt_rho = 65536;
    acc_ax = 0; acc_ay = 0; acc_dr = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_default_config();
    test_config_extremes();
    test_backpressure();
    test_random_config();
    repeat (NEIGHBOR_LAT) @(posedge clk);
    if (errors == 0 && pending_forces.size() == 0) begin
      $display("** sph_pair_force_accumulator_core: PASSED **");
    end else begin
      $display("** sph_pair_force_accumulator_core: FAILED **");
    end
    $finish;
  end
endmodule
